// ===== src/sorted_value_table_macros.svh =====
// assertion macros for the sorted value table checker
// expects clk and arst_n to be visible where the macros are used
`ifndef SORTED_VALUE_TABLE_MACROS_SVH
`define SORTED_VALUE_TABLE_MACROS_SVH

// same-cycle implication, disabled during reset
`define SVT_ASSERT_NOW(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("sorted_value_table check failed");

// next-cycle implication, disabled during reset
`define SVT_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("sorted_value_table check failed");

`endif

// ===== src/svt_pkg.sv =====
// shared types and constants for the sorted value table
// no dependencies
package svt_pkg;

	localparam int VALUE_W = 32;
	localparam int COUNT_W = 5;

	typedef enum logic [1:0] {
		KIND_INSERT = 2'd0,
		KIND_REMOVE = 2'd1,
		KIND_CLEAR  = 2'd2
	} kind_t;

	typedef enum logic [1:0] {
		ST_DONE      = 2'd0,
		ST_NOT_FOUND = 2'd1,
		ST_FULL      = 2'd2,
		ST_EMPTY     = 2'd3
	} status_t;

	// per-cycle command broadcast to every cell
	typedef struct packed {
		logic ins;
		logic rem;
		logic clr;
	} cell_op_t;

endpackage

// ===== src/svt_cell.sv =====
// one slot of the sorted table: occupancy bit, stored value, compare and shift
// depends on svt_pkg
module svt_cell (
	input  logic                                clk,
	input  logic                                arst_n,
	input  svt_pkg::cell_op_t                   op,
	input  logic signed [svt_pkg::VALUE_W-1:0]  value,
	input  logic                                left_valid,
	input  logic signed [svt_pkg::VALUE_W-1:0]  left_data,
	input  logic                                left_lt,
	input  logic                                right_valid,
	input  logic signed [svt_pkg::VALUE_W-1:0]  right_data,
	input  logic                                found,
	output logic                                valid,
	output logic signed [svt_pkg::VALUE_W-1:0]  data,
	output logic                                lt,
	output logic                                hit,
	output logic                                valid_nxt,
	output logic signed [svt_pkg::VALUE_W-1:0]  data_nxt
);
	import svt_pkg::*;

	logic                      valid_q;
	logic signed [VALUE_W-1:0] data_q;

	assign valid = valid_q;
	assign data  = data_q;
	// occupied and strictly below the request value
	assign lt    = valid_q && (data_q < value);
	// first slot not below the value holds an equal copy
	assign hit   = left_lt && !lt && valid_q && (data_q == value);

	always_comb begin
		valid_nxt = valid_q;
		data_nxt  = data_q;
		priority if (op.clr) begin
			valid_nxt = 1'b0;
		end else if (op.ins && !lt) begin
			valid_nxt = valid_q | left_valid;
			data_nxt  = left_lt ? value : left_data;
		end else if (op.rem && found && !lt) begin
			valid_nxt = right_valid;
			data_nxt  = right_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else begin
			valid_q <= valid_nxt;
		end
	end

	always_ff @(posedge clk) begin
		data_q <= data_nxt;
	end

endmodule

// ===== src/sorted_value_table.sv =====
// top level of the sorted value table: row of compare-and-shift cells plus result register
// depends on svt_pkg and svt_cell
//
//  channel   direction  handshake              payload
//  request   in         in_valid / in_ready    kind, value
//  result    out        out_valid / out_ready  status, entry_count, smallest_valid,
//                                              smallest_value
//
// every request is finished in the cycle it is accepted: all cells compare the
// broadcast value in parallel and shift toward their neighbor together
// the result is registered and appears in the next cycle; one request per cycle while
// out_ready stays high, set by the single result register
// a stalled result blocks new requests until it is taken
// reset empties the table (occupancy bits and count); stored values need no reset
module sorted_value_table #(
	parameter int CAPACITY = 16
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                in_valid,
	output logic                                in_ready,
	input  logic [1:0]                          kind,
	input  logic signed [svt_pkg::VALUE_W-1:0]  value,
	output logic                                out_valid,
	input  logic                                out_ready,
	output logic [1:0]                          status,
	output logic [svt_pkg::COUNT_W-1:0]         entry_count,
	output logic                                smallest_valid,
	output logic signed [svt_pkg::VALUE_W-1:0]  smallest_value
);
	import svt_pkg::*;

	localparam int CNT_W = $clog2(CAPACITY + 1);

	// cell row wiring
	logic [CAPACITY-1:0]       cv, clt, chit, cvn;
	logic signed [VALUE_W-1:0] cd  [CAPACITY];
	logic signed [VALUE_W-1:0] cdn [CAPACITY];

	logic                      accept;
	logic                      found, full, empty;
	cell_op_t                  op;
	status_t                   status_nxt;
	logic [CNT_W-1:0]          count_q, count_nxt;
	logic [CNT_W+COUNT_W-1:0]  count_wide;

	logic                      out_valid_q;
	logic [1:0]                status_q;
	logic [COUNT_W-1:0]        entry_count_q;
	logic                      smallest_valid_q;
	logic signed [VALUE_W-1:0] smallest_value_q;

	assign in_ready = !out_valid_q || out_ready;
	assign accept   = in_valid && in_ready;

	// occupancy is a thermometer, so the ends tell full and empty
	assign full  = cv[CAPACITY-1];
	assign empty = !cv[0];
	assign found = |chit;

	assign op.ins = accept && (kind == KIND_INSERT) && !full;
	assign op.rem = accept && (kind == KIND_REMOVE);
	assign op.clr = accept && (kind == KIND_CLEAR);

	for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
		logic                      l_valid, l_lt, r_valid;
		logic signed [VALUE_W-1:0] l_data, r_data;
		if (i == 0) begin : g_head
			// the head cell sees an always-smaller neighbor on its left
			assign l_valid = 1'b1;
			assign l_lt    = 1'b1;
			assign l_data  = '0;
		end else begin : g_mid
			assign l_valid = cv[i-1];
			assign l_lt    = clt[i-1];
			assign l_data  = cd[i-1];
		end
		if (i == CAPACITY - 1) begin : g_tail
			assign r_valid = 1'b0;
			assign r_data  = '0;
		end else begin : g_body
			assign r_valid = cv[i+1];
			assign r_data  = cd[i+1];
		end
		svt_cell u_cell (
			.clk        (clk),
			.arst_n     (arst_n),
			.op         (op),
			.value      (value),
			.left_valid (l_valid),
			.left_data  (l_data),
			.left_lt    (l_lt),
			.right_valid(r_valid),
			.right_data (r_data),
			.found      (found),
			.valid      (cv[i]),
			.data       (cd[i]),
			.lt         (clt[i]),
			.hit        (chit[i]),
			.valid_nxt  (cvn[i]),
			.data_nxt   (cdn[i])
		);
	end

	// status and count for the accepted request
	always_comb begin
		status_nxt = ST_DONE;
		count_nxt  = count_q;
		if (accept) begin
			unique case (kind)
				KIND_INSERT: begin
					if (full) begin
						status_nxt = ST_FULL;
					end else begin
						count_nxt = count_q + CNT_W'(1);
					end
				end
				KIND_REMOVE: begin
					if (found) begin
						count_nxt = count_q - CNT_W'(1);
					end else begin
						status_nxt = ST_NOT_FOUND;
					end
				end
				KIND_CLEAR: begin
					if (empty) begin
						status_nxt = ST_EMPTY;
					end
					count_nxt = '0;
				end
				default: begin
					// unused code: no change, reported as done
				end
			endcase
		end
	end

	// count field carries the low bits of the count
	assign count_wide = {{COUNT_W{1'b0}}, count_nxt};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			count_q <= count_nxt;
			if (accept) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// result payload, taken from the post-update head cell
	always_ff @(posedge clk) begin
		if (accept) begin
			status_q         <= status_nxt;
			entry_count_q    <= count_wide[COUNT_W-1:0];
			smallest_valid_q <= cvn[0];
			smallest_value_q <= cvn[0] ? cdn[0] : '0;
		end
	end

	assign out_valid      = out_valid_q;
	assign status         = status_q;
	assign entry_count    = entry_count_q;
	assign smallest_valid = smallest_valid_q;
	assign smallest_value = smallest_value_q;

endmodule

// ===== src/svt_checker.sv =====
// port-level checks for the sorted value table, bound to the top level
// depends on svt_pkg and sorted_value_table_macros.svh
`include "sorted_value_table_macros.svh"

module svt_checker #(
	parameter int CAPACITY = 16
) (
	input logic                                clk,
	input logic                                arst_n,
	input logic                                in_valid,
	input logic                                in_ready,
	input logic                                out_valid,
	input logic                                out_ready,
	input logic [1:0]                          status,
	input logic [svt_pkg::COUNT_W-1:0]         entry_count,
	input logic                                smallest_valid,
	input logic signed [svt_pkg::VALUE_W-1:0]  smallest_value
);
	import svt_pkg::*;

	localparam int CAP_W = $clog2(CAPACITY + 1) + COUNT_W;
	localparam logic [CAP_W-1:0] CAP_WIDE = CAP_W'(CAPACITY);

	// a stalled result keeps its status and smallest value
	`SVT_ASSERT_NEXT(a_hold, out_valid && !out_ready, out_valid && $stable(status) && $stable(smallest_value))
	// a dropped insert means the table was at capacity
	`SVT_ASSERT_NOW(a_full_count, out_valid && (status == ST_FULL), entry_count == CAP_WIDE[COUNT_W-1:0])
	// clearing an empty table leaves it empty
	`SVT_ASSERT_NOW(a_empty_clear, out_valid && (status == ST_EMPTY), (entry_count == '0) && !smallest_valid)
	// no head value without an entry
	`SVT_ASSERT_NOW(a_no_head, out_valid && !smallest_valid, (smallest_value == '0) && (entry_count == '0))
	// a request taken while the output is free shows a result next cycle
	`SVT_ASSERT_NEXT(a_result, in_valid && in_ready, out_valid)

endmodule

bind sorted_value_table svt_checker #(.CAPACITY(CAPACITY)) u_svt_checker (.*);
